FILE: src/usmg_pkg.sv
// Shared types, constants and arithmetic helpers of the UV sphere mesh generator.
package usmg_pkg;

   // Default bounds on the segment counts.
   localparam int unsigned DEF_MAX_WIDTH_SEGMENTS  = 256;
   localparam int unsigned DEF_MAX_HEIGHT_SEGMENTS = 256;

   // Register reset values and the matching reciprocals floor(2^32 / n).
   localparam logic [15:0] RADIUS_RESET   = 16'd256;
   localparam logic [8:0]  WIDTH_RESET    = 9'd32;
   localparam logic [8:0]  HEIGHT_RESET   = 9'd16;
   localparam logic [31:0] RECIP_W_RESET  = 32'h0800_0000;
   localparam logic [31:0] RECIP_H_RESET  = 32'h1000_0000;
   localparam logic [5:0]  DIV_LAST_STEP  = 6'd32;

   // Sine polynomial coefficients.
   localparam logic [15:0] SIN_A = 16'd51437;
   localparam logic [15:0] SIN_B = 16'd20954;
   localparam logic [11:0] SIN_C = 12'd2285;
   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   // Sine lanes.
   localparam int LANE_SIN_U = 0;
   localparam int LANE_COS_U = 1;
   localparam int LANE_SIN_V = 2;
   localparam int LANE_COS_V = 3;

   typedef enum logic [1:0] {
      REC_VERTEX    = 2'd0,
      REC_TRIANGLE  = 2'd1,
      REC_RANGE_ERR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RADIUS     = 2'd0,
      CSR_WIDTH_SEG  = 2'd1,
      CSR_HEIGHT_SEG = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STEP_VERTEX  = 2'd0,
      STEP_TRI_ABD = 2'd1,
      STEP_TRI_BCD = 2'd2
   } rec_step_type;

   // Payload of one grid point as it moves down the pipeline.
   typedef struct packed {
      logic             bad;
      logic             interior;
      logic             has_t1;
      logic             has_t2;
      logic             last_t1;
      logic [8:0]       row;
      logic [8:0]       col;
      logic [24:0]      n_pu;
      logic [24:0]      n_pv;
      logic [24:0]      n_tv;
      logic [24:0]      n_off;
      logic [16:0]      q_pu;
      logic [16:0]      q_pv;
      logic [16:0]      q_tv;
      logic [16:0]      q_off;
      logic [17:0]      corner_b;
      logic [17:0]      corner_c;
      logic [17:0]      tex_u;
      logic [16:0]      tex_v;
      logic [3:0][15:0] sx;
      logic [3:0][15:0] sx2;
      logic [3:0][15:0] st;
      logic [3:0]       sneg;
      logic [3:0][16:0] smag;
      logic [30:0]      p_cs;
      logic [30:0]      p_ss;
      logic [17:0]      pos_x;
      logic [17:0]      pos_y;
      logic [17:0]      pos_z;
      logic [15:0]      nrm_x;
      logic [15:0]      nrm_y;
      logic [15:0]      nrm_z;
   } item_type;

   // Quotient estimate floor(n * m / 2^32); low by at most one.
   function automatic logic [16:0] recip_q(logic [24:0] n, logic [31:0] m);
      logic [56:0] p;
      p = {32'd0, n} * {25'd0, m};
      return p[48:32];
   endfunction

   // Corrects the estimate with one multiply back, subtract and compare.
   function automatic logic [16:0] fix_q(logic [24:0] n, logic [16:0] q, logic [8:0] d);
      logic [25:0] qd;
      logic [25:0] r;
      qd = {9'd0, q} * {17'd0, d};
      r  = {1'b0, n} - qd;
      return (r >= {17'd0, d}) ? q + 17'd1 : q;
   endfunction

   // Clamps a magnitude to +32767.
   function automatic logic [15:0] sat15(logic [18:0] m);
      return (m > 19'd32767) ? 16'd32767 : m[15:0];
   endfunction

endpackage

FILE: src/usmg_if.sv
// Channel interfaces of the UV sphere mesh generator: grid points, records, registers.
interface usmg_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] grid_row;
   logic [8:0] grid_column;
   modport source (output valid, grid_row, grid_column, input ready);
   modport sink   (input valid, grid_row, grid_column, output ready);
endinterface

interface usmg_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         record_kind;
   logic signed [17:0] x_or_corner_a;
   logic signed [17:0] y_or_corner_b;
   logic signed [17:0] z_or_corner_c;
   logic signed [17:0] tex_u;
   logic [16:0]        tex_v;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               last_of_item;
   modport source (output valid, record_kind, x_or_corner_a, y_or_corner_b, z_or_corner_c,
                   tex_u, tex_v, normal_x, normal_y, normal_z, last_of_item, input ready);
   modport sink   (input valid, record_kind, x_or_corner_a, y_or_corner_b, z_or_corner_c,
                   tex_u, tex_v, normal_x, normal_y, normal_z, last_of_item, output ready);
endinterface

interface usmg_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/uv_sphere_mesh_generator.sv
// Top level of the UV sphere mesh generator: reciprocal unit, pipeline and record emitter.
//
// Use: each request on req_bus carries one grid point (row, column). The block answers on
// rsp_bus with a vertex record, followed for interior cells by one or two triangle
// records; last_of_item marks the final record of a grid point. A point outside the grid,
// or any point under a bad configuration, gives one range error record.
// Registers are written on csr_bus (radius, width segments, height segments); csr_bus is
// always ready. A write of either segment count starts a reciprocal division of 2^32 by
// the count, one quotient bit a cycle; req_bus is held off while it runs.
// The first record of a request reaches rsp_bus through the stage registers and the emitter
// register. Throughput, while rsp_bus is ready and no division runs: one grid point per
// cycle when it gives a single record, otherwise one record per cycle; a grid point gives
// 1 to 3 records, all through the single result port.
// A stalled rsp_bus freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous) empties the pipeline and loads the reset register values along
// with their reciprocals, so no division runs after reset.
module uv_sphere_mesh_generator #(
   parameter int unsigned MAX_WIDTH_SEGMENTS  = usmg_pkg::DEF_MAX_WIDTH_SEGMENTS,
   parameter int unsigned MAX_HEIGHT_SEGMENTS = usmg_pkg::DEF_MAX_HEIGHT_SEGMENTS
) (
   input logic        clock,
   input logic        reset,
   usmg_req_if.sink   req_bus,
   usmg_rsp_if.source rsp_bus,
   usmg_csr_if.sink   csr_bus
);
   import usmg_pkg::*;

   localparam int NSTAGE = 8;

   logic [15:0] radius_ff;
   logic [8:0]  width_ff, height_ff;
   logic [31:0] recip_w_ff, recip_h_ff;

   logic        div_busy_ff;
   logic [5:0]  div_cnt_ff;
   logic [8:0]  rem_w_ff, rem_h_ff;
   logic [31:0] quo_w_ff, quo_h_ff;
   logic [9:0]  cand_w, cand_h;
   logic [8:0]  rem_w_in, rem_h_in;
   logic [31:0] quo_w_in, quo_h_in;
   logic        csr_fire, seg_write;

   item_type    stage_ff [1:NSTAGE];
   item_type    stage_in [1:NSTAGE];
   logic [NSTAGE:1] vld_ff;

   logic         em_valid_ff;
   rec_step_type em_step_ff, em_step_in;
   item_type     em_ff;
   logic         cur_last;
   logic         pipe_adv;
   logic         cfg_bad;

   // Register port.
   assign csr_bus.ready = 1'b1;
   assign csr_fire  = csr_bus.valid;
   assign seg_write = csr_fire && (csr_bus.index == CSR_WIDTH_SEG ||
                                   csr_bus.index == CSR_HEIGHT_SEG);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_fire) begin
         case (csr_bus.index)
            CSR_RADIUS:     radius_ff <= csr_bus.data;
            CSR_WIDTH_SEG:  width_ff  <= csr_bus.data[8:0];
            CSR_HEIGHT_SEG: height_ff <= csr_bus.data[8:0];
            default: ;
         endcase
      end
   end

   // Restoring division of 2^32 by both segment counts, one quotient bit per cycle.
   always_comb begin
      cand_w = {rem_w_ff, (div_cnt_ff == 6'd0)};
      cand_h = {rem_h_ff, (div_cnt_ff == 6'd0)};
      if (cand_w >= {1'b0, width_ff}) begin
         rem_w_in = 9'(cand_w - {1'b0, width_ff});
         quo_w_in = {quo_w_ff[30:0], 1'b1};
      end else begin
         rem_w_in = cand_w[8:0];
         quo_w_in = {quo_w_ff[30:0], 1'b0};
      end
      if (cand_h >= {1'b0, height_ff}) begin
         rem_h_in = 9'(cand_h - {1'b0, height_ff});
         quo_h_in = {quo_h_ff[30:0], 1'b1};
      end else begin
         rem_h_in = cand_h[8:0];
         quo_h_in = {quo_h_ff[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
         recip_w_ff  <= RECIP_W_RESET;
         recip_h_ff  <= RECIP_H_RESET;
      end else if (seg_write) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 6'd1;
         if (div_cnt_ff == DIV_LAST_STEP) begin
            div_busy_ff <= 1'b0;
            recip_w_ff  <= quo_w_in;
            recip_h_ff  <= quo_h_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (seg_write) begin
         rem_w_ff <= '0;
         rem_h_ff <= '0;
         quo_w_ff <= '0;
         quo_h_ff <= '0;
      end else if (div_busy_ff) begin
         rem_w_ff <= rem_w_in;
         rem_h_ff <= rem_h_in;
         quo_w_ff <= quo_w_in;
         quo_h_ff <= quo_h_in;
      end
   end

   // The whole pipeline moves when the emitter can take its next grid point.
   assign pipe_adv      = !em_valid_ff || (rsp_bus.ready && cur_last);
   assign req_bus.ready = pipe_adv && !div_busy_ff;

   assign cfg_bad = (radius_ff == 16'd0) || (width_ff < 9'd3) || (height_ff < 9'd2) ||
                    ({23'd0, width_ff} > 32'(MAX_WIDTH_SEGMENTS)) ||
                    ({23'd0, height_ff} > 32'(MAX_HEIGHT_SEGMENTS));

   // Stage 1: range check, numerators and reciprocal multiplies.
   always_comb begin
      stage_in[1]       = '0;
      stage_in[1].row   = req_bus.grid_row;
      stage_in[1].col   = req_bus.grid_column;
      stage_in[1].bad   = cfg_bad || (req_bus.grid_row > height_ff) ||
                          (req_bus.grid_column > width_ff);
      stage_in[1].n_pu  = {req_bus.grid_column, 16'd0} + {17'd0, width_ff[8:1]};
      stage_in[1].n_pv  = {1'b0, req_bus.grid_row, 15'd0} + {17'd0, height_ff[8:1]};
      stage_in[1].n_tv  = {req_bus.grid_row, 16'd0} + {17'd0, height_ff[8:1]};
      stage_in[1].n_off = 25'h8000 + {17'd0, width_ff[8:1]};
      stage_in[1].q_pu  = recip_q(stage_in[1].n_pu, recip_w_ff);
      stage_in[1].q_pv  = recip_q(stage_in[1].n_pv, recip_h_ff);
      stage_in[1].q_tv  = recip_q(stage_in[1].n_tv, recip_h_ff);
      stage_in[1].q_off = recip_q(stage_in[1].n_off, recip_w_ff);
   end

   // Stage 2: quotient correction, corner indices and triangle selection.
   always_comb begin
      stage_in[2]          = stage_ff[1];
      stage_in[2].q_pu     = fix_q(stage_ff[1].n_pu, stage_ff[1].q_pu, width_ff);
      stage_in[2].q_pv     = fix_q(stage_ff[1].n_pv, stage_ff[1].q_pv, height_ff);
      stage_in[2].q_tv     = fix_q(stage_ff[1].n_tv, stage_ff[1].q_tv, height_ff);
      stage_in[2].q_off    = fix_q(stage_ff[1].n_off, stage_ff[1].q_off, width_ff);
      stage_in[2].corner_b = 18'({9'd0, stage_ff[1].row} * {8'd0, 10'({1'b0, width_ff}) + 10'd1})
                             + {9'd0, stage_ff[1].col};
      stage_in[2].corner_c = stage_in[2].corner_b + {9'd0, width_ff} + 18'd1;
      stage_in[2].interior = (stage_ff[1].row < height_ff) && (stage_ff[1].col < width_ff);
      stage_in[2].last_t1  = (stage_ff[1].row == height_ff - 9'd1);
      stage_in[2].has_t1   = stage_in[2].interior && (stage_ff[1].row != 9'd0);
      stage_in[2].has_t2   = stage_in[2].interior && !stage_in[2].last_t1;
   end

   // Stage 3: texture coordinates, sine arguments and x squared.
   always_comb begin
      logic [3:0][15:0] ph;
      logic [17:0]      off;
      logic [31:0]      sq;
      stage_in[3] = stage_ff[2];
      if (stage_ff[2].row == 9'd0) begin
         off = {1'b0, stage_ff[2].q_off};
      end else if (stage_ff[2].row == height_ff) begin
         off = 18'd0 - {1'b0, stage_ff[2].q_off};
      end else begin
         off = 18'd0;
      end
      stage_in[3].tex_u = {1'b0, stage_ff[2].q_pu} + off;
      stage_in[3].tex_v = 17'h10000 - stage_ff[2].q_tv;
      ph[LANE_SIN_U] = stage_ff[2].q_pu[15:0];
      ph[LANE_COS_U] = stage_ff[2].q_pu[15:0] + QUARTER_TURN;
      ph[LANE_SIN_V] = stage_ff[2].q_pv[15:0];
      ph[LANE_COS_V] = stage_ff[2].q_pv[15:0] + QUARTER_TURN;
      for (int k = 0; k < 4; k++) begin
         stage_in[3].sx[k] = {1'b0, ph[k][13:0], 1'b0};
         if (ph[k][14]) begin
            stage_in[3].sx[k] = 16'h8000 - {1'b0, ph[k][13:0], 1'b0};
         end
         stage_in[3].sneg[k] = ph[k][15];
         sq = {16'd0, stage_in[3].sx[k]} * {16'd0, stage_in[3].sx[k]};
         stage_in[3].sx2[k] = sq[30:15];
      end
   end

   // Stage 4: innermost polynomial term.
   always_comb begin
      logic [27:0] pc;
      stage_in[4] = stage_ff[3];
      for (int k = 0; k < 4; k++) begin
         pc = {16'd0, SIN_C} * {12'd0, stage_ff[3].sx2[k]};
         stage_in[4].st[k] = {3'd0, pc[27:15]};
      end
   end

   // Stage 5: middle polynomial term.
   always_comb begin
      logic [31:0] pb;
      stage_in[5] = stage_ff[4];
      for (int k = 0; k < 4; k++) begin
         pb = {16'd0, SIN_B - stage_ff[4].st[k]} * {16'd0, stage_ff[4].sx2[k]};
         stage_in[5].st[k] = pb[30:15];
      end
   end

   // Stage 6: sine magnitudes.
   always_comb begin
      logic [31:0] pa;
      stage_in[6] = stage_ff[5];
      for (int k = 0; k < 4; k++) begin
         pa = {16'd0, stage_ff[5].sx[k]} * {16'd0, SIN_A - stage_ff[5].st[k]};
         stage_in[6].smag[k] = pa[31:15];
      end
   end

   // Stage 7: angle products, normals and the y position.
   always_comb begin
      logic [33:0] pcs, pss;
      logic [18:0] mcs, mss;
      logic [32:0] ry;
      logic [18:0] my;
      logic [15:0] ny;
      stage_in[7] = stage_ff[6];
      pcs = {17'd0, stage_ff[6].smag[LANE_COS_U]} * {17'd0, stage_ff[6].smag[LANE_SIN_V]};
      pss = {17'd0, stage_ff[6].smag[LANE_SIN_U]} * {17'd0, stage_ff[6].smag[LANE_SIN_V]};
      stage_in[7].p_cs = pcs[30:0];
      stage_in[7].p_ss = pss[30:0];
      mcs = 19'((pcs + 34'd16384) >> 15);
      mss = 19'((pss + 34'd16384) >> 15);
      if (stage_ff[6].sneg[LANE_COS_U] ^ stage_ff[6].sneg[LANE_SIN_V]) begin
         stage_in[7].nrm_x = sat15(mcs);
      end else begin
         stage_in[7].nrm_x = 16'd0 - sat15(mcs);
      end
      if (stage_ff[6].sneg[LANE_SIN_U] ^ stage_ff[6].sneg[LANE_SIN_V]) begin
         stage_in[7].nrm_z = 16'd0 - mss[15:0];
      end else begin
         stage_in[7].nrm_z = sat15(mss);
      end
      ny = sat15({2'd0, stage_ff[6].smag[LANE_COS_V]});
      ry = {17'd0, radius_ff} * {16'd0, stage_ff[6].smag[LANE_COS_V]};
      my = 19'(({1'b0, ry} + 34'd16384) >> 15);
      if (stage_ff[6].sneg[LANE_COS_V]) begin
         stage_in[7].nrm_y = 16'd0 - stage_ff[6].smag[LANE_COS_V][15:0];
         stage_in[7].pos_y = 18'd0 - my[17:0];
      end else begin
         stage_in[7].nrm_y = ny;
         stage_in[7].pos_y = my[17:0];
      end
   end

   // Stage 8: x and z positions scaled by the radius.
   always_comb begin
      logic [46:0] px, pz;
      logic [47:0] rx, rz;
      stage_in[8] = stage_ff[7];
      px = {31'd0, radius_ff} * {16'd0, stage_ff[7].p_cs};
      pz = {31'd0, radius_ff} * {16'd0, stage_ff[7].p_ss};
      rx = {1'b0, px} + 48'h2000_0000;
      rz = {1'b0, pz} + 48'h2000_0000;
      if (stage_ff[7].sneg[LANE_COS_U] ^ stage_ff[7].sneg[LANE_SIN_V]) begin
         stage_in[8].pos_x = rx[47:30];
      end else begin
         stage_in[8].pos_x = 18'd0 - rx[47:30];
      end
      if (stage_ff[7].sneg[LANE_SIN_U] ^ stage_ff[7].sneg[LANE_SIN_V]) begin
         stage_in[8].pos_z = 18'd0 - rz[47:30];
      end else begin
         stage_in[8].pos_z = rz[47:30];
      end
   end

   // Pipeline registers; valid bits travel with the payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_adv) begin
         vld_ff <= {vld_ff[NSTAGE-1:1], req_bus.valid && req_bus.ready};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int k = 1; k <= NSTAGE; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Record emitter: sends the records of one grid point, one per cycle while rsp_bus is ready.
   always_comb begin
      if (em_ff.bad) begin
         cur_last = 1'b1;
      end else begin
         case (em_step_ff)
            STEP_VERTEX:  cur_last = !em_ff.interior;
            STEP_TRI_ABD: cur_last = em_ff.last_t1;
            STEP_TRI_BCD: cur_last = 1'b1;
            default:      cur_last = 1'b1;
         endcase
      end
      if (em_step_ff == STEP_VERTEX && em_ff.has_t1) begin
         em_step_in = STEP_TRI_ABD;
      end else begin
         em_step_in = STEP_TRI_BCD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
         em_step_ff  <= STEP_VERTEX;
      end else if (pipe_adv) begin
         em_valid_ff <= vld_ff[NSTAGE];
         em_step_ff  <= STEP_VERTEX;
      end else if (rsp_bus.ready) begin
         em_step_ff <= em_step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         em_ff <= stage_ff[NSTAGE];
      end
   end

   // Record fields.
   always_comb begin
      rsp_bus.valid         = em_valid_ff;
      rsp_bus.last_of_item  = cur_last;
      rsp_bus.record_kind   = REC_TRIANGLE;
      rsp_bus.x_or_corner_a = '0;
      rsp_bus.y_or_corner_b = '0;
      rsp_bus.z_or_corner_c = '0;
      rsp_bus.tex_u         = '0;
      rsp_bus.tex_v         = '0;
      rsp_bus.normal_x      = '0;
      rsp_bus.normal_y      = '0;
      rsp_bus.normal_z      = '0;
      if (em_ff.bad) begin
         rsp_bus.record_kind = REC_RANGE_ERR;
      end else begin
         case (em_step_ff)
            STEP_VERTEX: begin
               rsp_bus.record_kind   = REC_VERTEX;
               rsp_bus.x_or_corner_a = em_ff.pos_x;
               rsp_bus.y_or_corner_b = em_ff.pos_y;
               rsp_bus.z_or_corner_c = em_ff.pos_z;
               rsp_bus.tex_u         = em_ff.tex_u;
               rsp_bus.tex_v         = em_ff.tex_v;
               rsp_bus.normal_x      = em_ff.nrm_x;
               rsp_bus.normal_y      = em_ff.nrm_y;
               rsp_bus.normal_z      = em_ff.nrm_z;
            end
            STEP_TRI_ABD: begin
               rsp_bus.x_or_corner_a = em_ff.corner_b + 18'd1;
               rsp_bus.y_or_corner_b = em_ff.corner_b;
               rsp_bus.z_or_corner_c = em_ff.corner_c + 18'd1;
            end
            default: begin
               rsp_bus.x_or_corner_a = em_ff.corner_b;
               rsp_bus.y_or_corner_b = em_ff.corner_c;
               rsp_bus.z_or_corner_c = em_ff.corner_c + 18'd1;
            end
         endcase
      end
   end

endmodule

FILE: verif/tb.sv
// Self-checking testbench of the UV sphere mesh generator: stimulus, record prediction, checks.
`timescale 1ns / 100ps

module tb;
   import usmg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // One record as it is expected on the result channel.
   typedef struct {
      kind_type    kind;
      logic [17:0] xa;
      logic [17:0] yb;
      logic [17:0] zc;
      logic [17:0] tu;
      logic [16:0] tv;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic        last;
   } mesh_record_type;

   typedef struct {
      logic [8:0] row;
      logic [8:0] col;
   } grid_point_type;

   logic clock;
   logic reset;

   usmg_req_if req_bus ();
   usmg_rsp_if rsp_bus ();
   usmg_csr_if csr_bus ();

   uv_sphere_mesh_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the registers.
   logic [15:0] shadow_radius;
   logic [8:0]  shadow_width;
   logic [8:0]  shadow_height;

   grid_point_type  pending_points[$];
   mesh_record_type expected_records[$];
   int              fail_count;
   int              cycle_count;
   int              record_count;
   int              burst_left;
   int              gap_left;
   int              hold_left;
   bit              long_hold_done;

   // Sine of a phase in 1/65536 turn, Q1.15, same polynomial as the hardware.
   function automatic longint poly_sine(longint unsigned phase);
      longint unsigned p, x, x2, t, s;
      int unsigned     quad;
      p    = phase & 64'hFFFF;
      quad = int'(p >> 14);
      x    = (p & 64'h3FFF) << 1;
      if (quad[0]) x = 32768 - x;
      x2 = (x * x) >> 15;
      t  = (64'd2285 * x2) >> 15;
      t  = 64'd20954 - t;
      t  = (t * x2) >> 15;
      t  = 64'd51437 - t;
      s  = (x * t) >> 15;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   // Signed product rounded half away from zero on the magnitude.
   function automatic longint round_product(longint r, longint a, longint b, int sh);
      longint unsigned ma, mb, m;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      m  = (longint'(r) * ma * mb + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic mesh_record_type blank_record(kind_type kind, logic last);
      mesh_record_type rec;
      rec = '{kind: kind, xa: '0, yb: '0, zc: '0, tu: '0, tv: '0,
              nx: '0, ny: '0, nz: '0, last: last};
      return rec;
   endfunction

   // Works out every record that one grid point causes under the shadow registers.
   task automatic predict_records(logic [8:0] row, logic [8:0] col);
      longint          w, h, r, i, j, pu, pv, sp, cp, st, ct, off, nx, nv;
      longint          b, c;
      bit              interior;
      mesh_record_type rec;
      w = longint'(shadow_width);
      h = longint'(shadow_height);
      r = longint'(shadow_radius);
      i = longint'(row);
      j = longint'(col);
      if (r == 0 || w < 3 || h < 2 || w > DEF_MAX_WIDTH_SEGMENTS ||
          h > DEF_MAX_HEIGHT_SEGMENTS || i > h || j > w) begin
         expected_records.insert(expected_records.size(), blank_record(REC_RANGE_ERR, 1'b1));
         return;
      end
      pu = (j * 65536 + w / 2) / w;
      pv = (i * 32768 + h / 2) / h;
      sp = poly_sine(pu);
      cp = poly_sine(pu + 16384);
      st = poly_sine(pv);
      ct = poly_sine(pv + 16384);
      off = (32768 + w / 2) / w;
      if (i == h) off = -off;
      else if (i != 0) off = 0;
      interior = (i < h) && (j < w);

      // Vertex record: position, texture coordinate and unit normal.
      rec      = blank_record(REC_VERTEX, !interior);
      rec.xa   = 18'(-round_product(r, cp, st, 30));
      rec.yb   = 18'(round_product(r, ct, 1, 15));
      rec.zc   = 18'(round_product(r, sp, st, 30));
      rec.tu   = 18'(pu + off);
      rec.tv   = 17'(65536 - (i * 65536 + h / 2) / h);
      nx       = round_product(1, cp, st, 15);
      if (nx > 32767) nx = 32767;
      rec.nx   = 16'((-nx > 32767) ? 32767 : -nx);
      rec.ny   = 16'((ct > 32767) ? 32767 : ct);
      nv       = round_product(1, sp, st, 15);
      rec.nz   = 16'((nv > 32767) ? 32767 : nv);
      expected_records.insert(expected_records.size(), rec);
      if (!interior) return;

      // Triangles of the grid square whose upper-left corner is this point.
      b = i * (w + 1) + j;
      c = b + w + 1;
      if (i != 0) begin
         rec    = blank_record(REC_TRIANGLE, i == h - 1);
         rec.xa = 18'(b + 1);
         rec.yb = 18'(b);
         rec.zc = 18'(c + 1);
         expected_records.insert(expected_records.size(), rec);
      end
      if (i != h - 1) begin
         rec    = blank_record(REC_TRIANGLE, 1'b1);
         rec.xa = 18'(b);
         rec.yb = 18'(c);
         rec.zc = 18'(c + 1);
         expected_records.insert(expected_records.size(), rec);
      end
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request acceptance, register shadowing and the run time limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_RADIUS:     shadow_radius = csr_bus.data;
               CSR_WIDTH_SEG:  shadow_width  = csr_bus.data[8:0];
               CSR_HEIGHT_SEG: shadow_height = csr_bus.data[8:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_records(req_bus.grid_row, req_bus.grid_column);
            void'(pending_points.pop_front());
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
               burst_left = int'($urandom_range(1, 16));
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            end
         end
      end
   end

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_bus.valid <= 1'b0;
      end else if (pending_points.size() != 0) begin
         req_bus.valid       <= 1'b1;
         req_bus.grid_row    <= pending_points[0].row;
         req_bus.grid_column <= pending_points[0].col;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Record receiver: stall pattern that rotates through four modes, one long hold-off.
   always @(negedge clock) begin
      if (!long_hold_done && record_count >= 150) begin
         long_hold_done = 1'b1;
         hold_left      = 300;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         case ((cycle_count / 64) % 4)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= ($urandom_range(0, 1) == 0);
            2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Record monitor: compares each accepted record with the oldest expectation.
   always @(posedge clock) begin
      mesh_record_type exp_rec;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         record_count <= record_count + 1;
         if (expected_records.size() == 0) begin
            $error("record with no expectation pending, kind %0d", rsp_bus.record_kind);
            fail_count++;
         end else begin
            exp_rec = expected_records.pop_front();
            if (rsp_bus.record_kind !== exp_rec.kind) begin
               $error("record_kind: expected %0d, got %0d", exp_rec.kind, rsp_bus.record_kind);
               fail_count++;
            end
            if (rsp_bus.x_or_corner_a !== exp_rec.xa) begin
               $error("x_or_corner_a: expected %0d, got %0d",
                      $signed(exp_rec.xa), rsp_bus.x_or_corner_a);
               fail_count++;
            end
            if (rsp_bus.y_or_corner_b !== exp_rec.yb) begin
               $error("y_or_corner_b: expected %0d, got %0d",
                      $signed(exp_rec.yb), rsp_bus.y_or_corner_b);
               fail_count++;
            end
            if (rsp_bus.z_or_corner_c !== exp_rec.zc) begin
               $error("z_or_corner_c: expected %0d, got %0d",
                      $signed(exp_rec.zc), rsp_bus.z_or_corner_c);
               fail_count++;
            end
            if (rsp_bus.tex_u !== exp_rec.tu) begin
               $error("tex_u: expected %0d, got %0d", $signed(exp_rec.tu), rsp_bus.tex_u);
               fail_count++;
            end
            if (rsp_bus.tex_v !== exp_rec.tv) begin
               $error("tex_v: expected %0d, got %0d", exp_rec.tv, rsp_bus.tex_v);
               fail_count++;
            end
            if (rsp_bus.normal_x !== exp_rec.nx) begin
               $error("normal_x: expected %0d, got %0d", $signed(exp_rec.nx), rsp_bus.normal_x);
               fail_count++;
            end
            if (rsp_bus.normal_y !== exp_rec.ny) begin
               $error("normal_y: expected %0d, got %0d", $signed(exp_rec.ny), rsp_bus.normal_y);
               fail_count++;
            end
            if (rsp_bus.normal_z !== exp_rec.nz) begin
               $error("normal_z: expected %0d, got %0d", $signed(exp_rec.nz), rsp_bus.normal_z);
               fail_count++;
            end
            if (rsp_bus.last_of_item !== exp_rec.last) begin
               $error("last_of_item: expected %0d, got %0d", exp_rec.last, rsp_bus.last_of_item);
               fail_count++;
            end
         end
      end
   end

   // Register write; the upper bits of a segment count carry random junk.
   task automatic write_register(csr_index_type index, logic [15:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_geometry(logic [15:0] radius, logic [8:0] width, logic [8:0] height);
      write_register(CSR_RADIUS, radius);
      write_register(CSR_WIDTH_SEG, {7'($urandom), width});
      write_register(CSR_HEIGHT_SEG, {7'($urandom), height});
   endtask

   task automatic wait_idle();
      while (pending_points.size() != 0 || expected_records.size() != 0) @(posedge clock);
      repeat (15) @(posedge clock);
   endtask

   task automatic queue_point(int row, int col);
      grid_point_type pt;
      pt.row = 9'(row);
      pt.col = 9'(col);
      pending_points.insert(pending_points.size(), pt);
   endtask

   // Mostly points on the grid, a few anywhere in the field range.
   task automatic queue_random_points(int count, int w, int h);
      repeat (count) begin
         if ($urandom_range(0, 9) < 8)
            queue_point(int'($urandom_range(0, h)), int'($urandom_range(0, w)));
         else
            queue_point(int'($urandom_range(0, 511)), int'($urandom_range(0, 511)));
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.grid_row    = '0;
      req_bus.grid_column = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = CSR_RADIUS;
      csr_bus.data   = '0;
      shadow_radius  = RADIUS_RESET;
      shadow_width   = WIDTH_RESET;
      shadow_height  = HEIGHT_RESET;
      fail_count     = 0;
      cycle_count    = 0;
      record_count   = 0;
      burst_left     = 4;
      gap_left       = 0;
      hold_left      = 0;
      long_hold_done = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed points under the reset geometry: poles, seams, corners, out of range.
      queue_point(0, 0);
      queue_point(0, 31);
      queue_point(0, 32);
      queue_point(16, 0);
      queue_point(16, 32);
      queue_point(15, 5);
      queue_point(1, 1);
      queue_point(8, 16);
      queue_point(4, 8);
      queue_point(17, 0);
      queue_point(0, 33);
      queue_point(511, 511);
      queue_point(5, 300);
      queue_random_points(30, 32, 16);
      wait_idle();

      // Smallest legal grid with the largest radius.
      write_geometry(16'hFFFF, 9'd3, 9'd2);
      queue_point(0, 0);
      queue_point(1, 2);
      queue_point(2, 3);
      queue_random_points(30, 3, 2);
      wait_idle();

      // Largest grid with the smallest radius; also takes the long receiver hold-off.
      write_geometry(16'd1, 9'd256, 9'd256);
      queue_point(256, 256);
      queue_point(255, 255);
      queue_point(0, 255);
      queue_random_points(60, 256, 256);
      wait_idle();

      write_geometry(16'd1000, 9'd7, 9'd5);
      queue_random_points(40, 7, 5);
      wait_idle();

      // Bad configurations: zero radius, too few or too many segments.
      write_register(CSR_RADIUS, 16'd0);
      queue_random_points(12, 7, 5);
      wait_idle();
      write_geometry(16'd300, 9'd2, 9'd10);
      queue_random_points(12, 2, 10);
      wait_idle();
      write_geometry(16'd300, 9'd10, 9'd1);
      queue_random_points(12, 10, 1);
      wait_idle();
      write_geometry(16'd300, 9'd511, 9'd300);
      queue_random_points(12, 300, 300);
      wait_idle();
      write_geometry(16'd300, 9'd257, 9'd257);
      queue_random_points(12, 257, 257);
      wait_idle();

      // Back to a sane geometry; a write to an unused index must change nothing.
      write_geometry(16'd256, 9'd32, 9'd16);
      write_register(csr_index_type'(2'd3), 16'hFFFF);
      queue_random_points(40, 32, 16);
      wait_idle();

      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
